### design/joystick_disc_mapper_unit_assert.svh
// Assertion macros for the joystick disc mapper.
// Depends on nothing; taken in by the top level.
`ifndef JOYSTICK_DISC_MAPPER_UNIT_ASSERT_SVH
`define JOYSTICK_DISC_MAPPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define JDM_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("joystick_disc_mapper_unit: assertion failed");

// Next-cycle implication, disabled in reset.
`define JDM_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("joystick_disc_mapper_unit: assertion failed");

`endif

### design/jdm_pkg.sv
// Shared types, constants and helpers for the joystick disc mapper.
// No dependencies.
package jdm_pkg;

   localparam int JDM_SAMPLE_BITS   = 12;
   localparam int JDM_CALIB_SAMPLES = 10;
   localparam int JDM_QUEUE_DEPTH   = 4;
   localparam int JDM_TILT_W        = 16;
   localparam int JDM_MAG_W         = 15;
   localparam int JDM_PROD_W        = 2 * JDM_MAG_W;
   localparam int JDM_ARG_W         = 29;
   localparam int JDM_Q14_SHIFT     = 15 - JDM_SAMPLE_BITS;

   localparam logic [JDM_MAG_W-1:0]  JDM_Q14_ONE        = JDM_MAG_W'(16384);
   localparam logic [JDM_ARG_W-1:0]  JDM_ROOT_ARG_ONE   = JDM_ARG_W'(1 << 28);
   localparam logic [JDM_TILT_W-1:0] JDM_DEADZONE_RESET = JDM_TILT_W'(328);

   typedef struct packed {
      logic [JDM_SAMPLE_BITS-1:0] horizontal_sample;
      logic [JDM_SAMPLE_BITS-1:0] vertical_sample;
      logic                       button_level;
   } jdm_req_type;

   typedef struct packed {
      logic signed [JDM_TILT_W-1:0] tilt_horizontal;
      logic signed [JDM_TILT_W-1:0] tilt_vertical;
      logic                         tilted;
      logic                         pressed_edge;
      logic                         released_edge;
      logic                         calibrating;
   } jdm_rsp_type;

   typedef struct packed {
      logic                 neg;
      logic [JDM_MAG_W-1:0] mag;
   } jdm_axis_type;

   typedef struct packed {
      logic         calibrating;
      logic         pressed_edge;
      logic         released_edge;
      jdm_axis_type horizontal;
      jdm_axis_type vertical;
   } jdm_entry_type;

   // Offset from centre in Q1.14, saturated to +-1.0.
   function automatic jdm_axis_type jdm_to_q14(input logic [JDM_SAMPLE_BITS-1:0] sample,
                                               input logic [JDM_SAMPLE_BITS-1:0] centre);
      jdm_axis_type               r;
      logic [JDM_SAMPLE_BITS-1:0] diff;
      logic [JDM_MAG_W-1:0]       scaled;
      r.neg  = sample < centre;
      diff   = r.neg ? centre - sample : sample - centre;
      scaled = JDM_MAG_W'(diff) << JDM_Q14_SHIFT;
      r.mag  = (scaled > JDM_Q14_ONE) ? JDM_Q14_ONE : scaled;
      return r;
   endfunction

endpackage

### design/joystick_disc_mapper_unit.sv
// Joystick disc mapper: in the back end a mapped sample is squared, rooted and scaled
// into the result register, a calibration sample goes there directly. A new sample is
// taken only once the last is in the result register, paced by the shared multiplier
// and the 15-step square roots. The last calibration sample holds input off while the
// centres are divided. Reset is synchronous and active high: calibration restarts, centres
// and edge history clear, the deadzone threshold returns to 328, queue and result empty.
`include "joystick_disc_mapper_unit_assert.svh"
module joystick_disc_mapper_unit import jdm_pkg::*; #(
   parameter int CALIB_SAMPLES = JDM_CALIB_SAMPLES,
   parameter int QUEUE_DEPTH   = JDM_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  jdm_req_type           req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output jdm_rsp_type           rsp_data,
   input  logic                  csr_write_enable,
   input  logic [JDM_TILT_W-1:0] csr_write_data
);

   logic [JDM_TILT_W-1:0] deadzone_ff, deadzone_in;
   logic                  q_push, q_full, q_pop, q_empty;
   jdm_entry_type         q_wr_data, q_rd_data;

   assign deadzone_in = csr_write_enable ? csr_write_data : deadzone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= JDM_DEADZONE_RESET;
      end else begin
         deadzone_ff <= deadzone_in;
      end
   end

   jdm_front #(
      .CALIB_SAMPLES (CALIB_SAMPLES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_wr_data),
      .q_full   (q_full)
   );

   jdm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   jdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (deadzone_ff),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   `JDM_ASSERT_IMPLY(a_calib_no_tilt, clock, reset, !rsp_empty && rsp_data.calibrating,
                     rsp_data.tilt_horizontal == '0 && rsp_data.tilt_vertical == '0
                     && !rsp_data.tilted)
   `JDM_ASSERT_IMPLY(a_edges_exclusive, clock, reset, !rsp_empty,
                     !(rsp_data.pressed_edge && rsp_data.released_edge))
   `JDM_ASSERT_IMPLY(a_tilt_range, clock, reset, !rsp_empty,
                     rsp_data.tilt_horizontal >= -16'sd16384
                     && rsp_data.tilt_horizontal <= 16'sd16384
                     && rsp_data.tilt_vertical >= -16'sd16384
                     && rsp_data.tilt_vertical <= 16'sd16384)
   `JDM_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, q_push, !q_full)
   `JDM_ASSERT_NEXT(a_pop_taken, clock, reset, q_pop, !q_empty || !q_pop)

endmodule

### design/jdm_front.sv
// Front end: takes samples, runs centre calibration and the centre division,
// turns later samples into Q1.14 offsets and detects button edges. Uses jdm_pkg.
module jdm_front import jdm_pkg::*; #(
   parameter int CALIB_SAMPLES = JDM_CALIB_SAMPLES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  jdm_req_type   req_data,
   output logic          q_push,
   output jdm_entry_type q_data,
   input  logic          q_full
);

   localparam int CNT_W       = $clog2(CALIB_SAMPLES + 1);
   localparam int SUM_W       = JDM_SAMPLE_BITS + $clog2(CALIB_SAMPLES);
   localparam int RECIP_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
   localparam int PROD_W      = 2 * SUM_W + 1;

   localparam logic [CNT_W-1:0] CALIB_LAST = CNT_W'(CALIB_SAMPLES);
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(CALIB_SAMPLES / 2);
   // ceil(2^RECIP_SHIFT / CALIB_SAMPLES): exact quotient for any sum below 2^SUM_W
   localparam logic [SUM_W:0]   RECIP      =
      (SUM_W + 1)'(((1 << RECIP_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);

   localparam logic F_RUN    = 1'b0;
   localparam logic F_DIVIDE = 1'b1;

   logic                       state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [SUM_W-1:0]           hsum_ff, hsum_in, vsum_ff, vsum_in;
   logic [JDM_SAMPLE_BITS-1:0] hcentre_ff, hcentre_in, vcentre_ff, vcentre_in;
   logic                       was_pressed_ff, was_pressed_in;

   logic                       accept, calib, pressed;
   logic [SUM_W-1:0]           hsum_add, vsum_add;
   logic [PROD_W-1:0]          hprod, vprod;

   assign req_full = (state_ff != F_RUN) || q_full;
   assign accept   = req_push && !req_full;
   assign calib    = count_ff != CALIB_LAST;
   assign pressed  = !req_data.button_level;
   assign hsum_add = hsum_ff + SUM_W'(req_data.horizontal_sample);
   assign vsum_add = vsum_ff + SUM_W'(req_data.vertical_sample);
   assign hprod    = PROD_W'(hsum_ff) * PROD_W'(RECIP);
   assign vprod    = PROD_W'(vsum_ff) * PROD_W'(RECIP);

   assign q_push               = accept;
   assign q_data.calibrating   = calib;
   assign q_data.pressed_edge  = pressed && !was_pressed_ff;
   assign q_data.released_edge = !pressed && was_pressed_ff;
   assign q_data.horizontal    = jdm_to_q14(req_data.horizontal_sample, hcentre_ff);
   assign q_data.vertical      = jdm_to_q14(req_data.vertical_sample, vcentre_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      hsum_in        = hsum_ff;
      vsum_in        = vsum_ff;
      hcentre_in     = hcentre_ff;
      vcentre_in     = vcentre_ff;
      was_pressed_in = accept ? pressed : was_pressed_ff;
      case (state_ff)
         F_RUN: begin
            if (accept && calib) begin
               count_in = count_ff + CNT_W'(1);
               hsum_in  = hsum_add;
               vsum_in  = vsum_add;
               if (count_ff + CNT_W'(1) == CALIB_LAST) begin
                  hsum_in  = hsum_add + ROUND_HALF;
                  vsum_in  = vsum_add + ROUND_HALF;
                  state_in = F_DIVIDE;
               end
            end
         end
         F_DIVIDE: begin
            hcentre_in = hprod[RECIP_SHIFT +: JDM_SAMPLE_BITS];
            vcentre_in = vprod[RECIP_SHIFT +: JDM_SAMPLE_BITS];
            state_in   = F_RUN;
         end
         default: state_in = F_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_RUN;
         count_ff       <= '0;
         hsum_ff        <= '0;
         vsum_ff        <= '0;
         hcentre_ff     <= '0;
         vcentre_ff     <= '0;
         was_pressed_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         hsum_ff        <= hsum_in;
         vsum_ff        <= vsum_in;
         hcentre_ff     <= hcentre_in;
         vcentre_ff     <= vcentre_in;
         was_pressed_ff <= was_pressed_in;
      end
   end

endmodule

### design/jdm_queue.sv
// Short queue of classified transactions between front and back end.
// Uses jdm_pkg for the entry type.
module jdm_queue import jdm_pkg::*; #(
   parameter int DEPTH = JDM_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  jdm_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output jdm_entry_type pop_data,
   output logic          empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   jdm_entry_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/jdm_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Uses jdm_pkg for widths.
module jdm_isqrt import jdm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [JDM_ARG_W-1:0] arg,
   output logic                 busy,
   output logic [JDM_MAG_W-1:0] root
);

   logic [JDM_ARG_W-1:0] rem_ff, rem_in, bit_ff, bit_in;
   logic [JDM_ARG_W:0]   root_ff, root_in, trial;
   logic                 busy_ff, busy_in, ge;

   assign trial = root_ff + (JDM_ARG_W + 1)'(bit_ff);
   assign ge    = {1'b0, rem_ff} >= trial;
   assign busy  = busy_ff;
   assign root  = root_ff[JDM_MAG_W-1:0];

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = arg;
         root_in = '0;
         bit_in  = JDM_ROOT_ARG_ONE;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in  = rem_ff - trial[JDM_ARG_W-1:0];
            root_in = (root_ff >> 1) + (JDM_ARG_W + 1)'(bit_ff);
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         busy_in = !bit_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

endmodule

### design/jdm_back.sv
// Back end: disc mapping with one shared multiplier and two root units,
// deadzone test and the result register. Uses jdm_pkg and jdm_isqrt.
module jdm_back import jdm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [JDM_TILT_W-1:0] threshold,
   input  logic                  q_empty,
   input  jdm_entry_type         q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   output jdm_rsp_type           rsp_data,
   input  logic                  rsp_pop
);

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_SQH   = 3'd1;
   localparam logic [2:0] B_SQV   = 3'd2;
   localparam logic [2:0] B_START = 3'd3;
   localparam logic [2:0] B_ROOT  = 3'd4;
   localparam logic [2:0] B_MULH  = 3'd5;
   localparam logic [2:0] B_MULV  = 3'd6;
   localparam logic [2:0] B_OUT   = 3'd7;

   logic [2:0]            state_ff, state_in;
   jdm_entry_type         entry_ff, entry_in;
   logic [JDM_PROD_W-1:0] sq_h_ff, sq_h_in, sq_v_ff, sq_v_in;
   logic [JDM_MAG_W-1:0]  th_mag_ff, th_mag_in, tv_mag_ff, tv_mag_in;
   logic                  out_valid_ff, out_valid_in;
   jdm_rsp_type           out_ff, out_in;

   logic [JDM_MAG_W-1:0]  mul_a, mul_b, root_h, root_v, th_mag, tv_mag;
   logic [JDM_PROD_W-1:0] mul_prod;
   logic [JDM_ARG_W-1:0]  arg_h, arg_v;
   logic                  start, busy_h, busy_v, out_free;
   logic [JDM_TILT_W:0]   tilt_sum;
   jdm_rsp_type           result;

   // h' takes its root from v, v' from h.
   assign arg_h = JDM_ROOT_ARG_ONE - JDM_ARG_W'(sq_v_ff >> 1);
   assign arg_v = JDM_ROOT_ARG_ONE - JDM_ARG_W'(sq_h_ff >> 1);
   assign start = state_ff == B_START;

   jdm_isqrt u_root_h (
      .clock (clock),
      .reset (reset),
      .start (start),
      .arg   (arg_h),
      .busy  (busy_h),
      .root  (root_h)
   );

   jdm_isqrt u_root_v (
      .clock (clock),
      .reset (reset),
      .start (start),
      .arg   (arg_v),
      .busy  (busy_v),
      .root  (root_v)
   );

   always_comb begin
      case (state_ff)
         B_SQH: begin
            mul_a = entry_ff.horizontal.mag;
            mul_b = entry_ff.horizontal.mag;
         end
         B_SQV: begin
            mul_a = entry_ff.vertical.mag;
            mul_b = entry_ff.vertical.mag;
         end
         B_MULH: begin
            mul_a = entry_ff.horizontal.mag;
            mul_b = root_h;
         end
         B_MULV: begin
            mul_a = entry_ff.vertical.mag;
            mul_b = root_v;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = JDM_PROD_W'(mul_a) * JDM_PROD_W'(mul_b);

   assign th_mag   = entry_ff.calibrating ? '0 : th_mag_ff;
   assign tv_mag   = entry_ff.calibrating ? '0 : tv_mag_ff;
   assign tilt_sum = (JDM_TILT_W + 1)'(th_mag) + (JDM_TILT_W + 1)'(tv_mag);

   always_comb begin
      result.tilt_horizontal = entry_ff.horizontal.neg ? -JDM_TILT_W'(th_mag)
                                                       : JDM_TILT_W'(th_mag);
      result.tilt_vertical   = entry_ff.vertical.neg ? -JDM_TILT_W'(tv_mag)
                                                     : JDM_TILT_W'(tv_mag);
      result.tilted          = !entry_ff.calibrating
                               && (tilt_sum > (JDM_TILT_W + 1)'(threshold));
      result.pressed_edge    = entry_ff.pressed_edge;
      result.released_edge   = entry_ff.released_edge;
      result.calibrating     = entry_ff.calibrating;
   end

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      sq_h_in      = sq_h_ff;
      sq_v_in      = sq_v_ff;
      th_mag_in    = th_mag_ff;
      tv_mag_in    = tv_mag_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               entry_in = q_data;
               state_in = q_data.calibrating ? B_OUT : B_SQH;
            end
         end
         B_SQH: begin
            sq_h_in  = mul_prod;
            state_in = B_SQV;
         end
         B_SQV: begin
            sq_v_in  = mul_prod;
            state_in = B_START;
         end
         B_START: state_in = B_ROOT;
         B_ROOT: begin
            if (!busy_h && !busy_v) begin
               state_in = B_MULH;
            end
         end
         B_MULH: begin
            th_mag_in = mul_prod[2*JDM_MAG_W-2:JDM_MAG_W-1];
            state_in  = B_MULV;
         end
         B_MULV: begin
            tv_mag_in = mul_prod[2*JDM_MAG_W-2:JDM_MAG_W-1];
            state_in  = B_OUT;
         end
         B_OUT: begin
            if (out_free) begin
               out_in       = result;
               out_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      sq_h_ff   <= sq_h_in;
      sq_v_ff   <= sq_v_in;
      th_mag_ff <= th_mag_in;
      tv_mag_ff <= tv_mag_in;
      out_ff    <= out_in;
   end

endmodule

### tb/tb.sv
// Self-checking bench for joystick_disc_mapper_unit: queue-style drive of samples, a tilt
// predictor inside a small scoreboard class, and deadzone changes between idling phases.
// Depends on jdm_pkg and the unit's RTL.
module tb;
   import jdm_pkg::*;

   class tilt_scoreboard;
      jdm_rsp_type           tilt_queue[$];
      logic [JDM_TILT_W-1:0] deadzone = JDM_DEADZONE_RESET;
      int unsigned           calib_taken = 0;
      int unsigned           h_sum = 0;
      int unsigned           v_sum = 0;
      int                    h_centre = 0;
      int                    v_centre = 0;
      bit                    was_pressed = 1'b0;
      int                    errors = 0;
      int                    checked = 0;
      int                    n_calib = 0;
      int                    n_tilted = 0;
      int                    n_press = 0;
      int                    n_release = 0;

      function int unsigned root_floor(longint unsigned arg);
         int unsigned    r;
         longint unsigned trial;
         r = 0;
         for (int b = 15; b >= 0; b--) begin
            trial = r | (1 << b);
            if (trial * trial <= arg)
               r = trial;
         end
         return r;
      endfunction

      // Offset from centre in Q1.14, clipped to +-1.0
      function int axis_q14(int sample, int centre);
         int mag;
         mag = (sample < centre) ? centre - sample : sample - centre;
         mag = (mag << 15) >> JDM_SAMPLE_BITS;
         if (mag > int'(JDM_Q14_ONE))
            mag = int'(JDM_Q14_ONE);
         return (sample < centre) ? -mag : mag;
      endfunction

      // a * sqrt(1 - o^2/2), truncated towards zero
      function int disc_scale(int a, int o);
         longint unsigned om, am, s, r;
         om = (o < 0) ? -o : o;
         am = (a < 0) ? -a : a;
         s  = root_floor((64'd1 << 28) - ((om * om) >> 1));
         r  = (am * s) >> 14;
         return (a < 0) ? -int'(r) : int'(r);
      endfunction

      function void note_sample(jdm_req_type req);
         jdm_rsp_type want;
         int          h, v, th, tv;
         bit          pressed;
         pressed = !req.button_level;
         want    = '0;
         if (calib_taken < JDM_CALIB_SAMPLES) begin
            want.calibrating = 1'b1;
            h_sum += req.horizontal_sample;
            v_sum += req.vertical_sample;
            calib_taken++;
            if (calib_taken == JDM_CALIB_SAMPLES) begin
               h_centre = (h_sum + JDM_CALIB_SAMPLES / 2) / JDM_CALIB_SAMPLES;
               v_centre = (v_sum + JDM_CALIB_SAMPLES / 2) / JDM_CALIB_SAMPLES;
            end
         end else begin
            h  = axis_q14(req.horizontal_sample, h_centre);
            v  = axis_q14(req.vertical_sample, v_centre);
            th = disc_scale(h, v);
            tv = disc_scale(v, h);
            want.tilt_horizontal = JDM_TILT_W'(th);
            want.tilt_vertical   = JDM_TILT_W'(tv);
            want.tilted = ((th < 0 ? -th : th) + (tv < 0 ? -tv : tv)) > int'(deadzone);
         end
         want.pressed_edge  = pressed && !was_pressed;
         want.released_edge = !pressed && was_pressed;
         was_pressed = pressed;
         tilt_queue.push_back(want);
      endfunction

      function void field_check(string name, logic signed [JDM_TILT_W-1:0] want,
                                logic signed [JDM_TILT_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_tilt(jdm_rsp_type got);
         jdm_rsp_type want;
         if (tilt_queue.size() == 0) begin
            $error("result with no transaction outstanding");
            errors++;
            return;
         end
         want = tilt_queue.pop_front();
         checked++;
         n_calib   += want.calibrating;
         n_tilted  += want.tilted;
         n_press   += want.pressed_edge;
         n_release += want.released_edge;
         field_check("tilt_horizontal", want.tilt_horizontal, got.tilt_horizontal);
         field_check("tilt_vertical", want.tilt_vertical, got.tilt_vertical);
         field_check("tilted", JDM_TILT_W'(want.tilted), JDM_TILT_W'(got.tilted));
         field_check("pressed_edge", JDM_TILT_W'(want.pressed_edge),
                     JDM_TILT_W'(got.pressed_edge));
         field_check("released_edge", JDM_TILT_W'(want.released_edge),
                     JDM_TILT_W'(got.released_edge));
         field_check("calibrating", JDM_TILT_W'(want.calibrating),
                     JDM_TILT_W'(got.calibrating));
      endfunction

      function int pending();
         return tilt_queue.size();
      endfunction
   endclass

   localparam int RANDOM_PER_PHASE = 247;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   jdm_req_type           req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   jdm_rsp_type           rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [JDM_TILT_W-1:0] csr_write_data = '0;

   tilt_scoreboard tilt_check = new;
   int             send_idle_pct = 0;
   int             pop_stall_pct = 0;
   int             samples_sent = 0;
   bit             button_held = 1'b0;

   joystick_disc_mapper_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_sample(int x);
      return (x < 0) ? 0 : (x > 4095) ? 4095 : x;
   endfunction

   function automatic int extreme_sample(int centre);
      case ($urandom_range(2))
         0: return 0;
         1: return 4095;
         default: return centre;
      endcase
   endfunction

   function automatic jdm_req_type random_sample();
      jdm_req_type s;
      int          kind, hc, vc;
      hc   = tilt_check.h_centre;
      vc   = tilt_check.v_centre;
      kind = $urandom_range(99);
      if (kind < 50) begin
         s.horizontal_sample = JDM_SAMPLE_BITS'($urandom_range(4095));
         s.vertical_sample   = JDM_SAMPLE_BITS'($urandom_range(4095));
      end else if (kind < 70) begin
         // around the rest position, where the deadzone decides
         s.horizontal_sample =
            JDM_SAMPLE_BITS'(clamp_sample(hc + int'($urandom_range(80)) - 40));
         s.vertical_sample   =
            JDM_SAMPLE_BITS'(clamp_sample(vc + int'($urandom_range(80)) - 40));
      end else if (kind < 85) begin
         s.horizontal_sample = JDM_SAMPLE_BITS'(extreme_sample(hc));
         s.vertical_sample   = JDM_SAMPLE_BITS'(extreme_sample(vc));
      end else if (kind < 93) begin
         s.horizontal_sample = JDM_SAMPLE_BITS'(hc);
         s.vertical_sample   = JDM_SAMPLE_BITS'($urandom_range(4095));
      end else begin
         s.horizontal_sample = JDM_SAMPLE_BITS'($urandom_range(4095));
         s.vertical_sample   = JDM_SAMPLE_BITS'(vc);
      end
      if ($urandom_range(99) < 30)
         button_held = !button_held;
      s.button_level = !button_held;
      return s;
   endfunction

   task automatic send_sample(input jdm_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      tilt_check.note_sample(item);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (tilt_check.pending() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_deadzone(input logic [JDM_TILT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tilt_check.deadzone = value;
   endtask

   task automatic send_directed();
      int          calib_v[10] = '{100, 4000, 2000, 2100, 1900, 3000, 1000, 2500, 1500, 2051};
      int          offs_h[12]  = '{0, -4095, 4095, 0, 0, -4095, 4095, -4095, 4095, 1, 20, 21};
      int          offs_v[12]  = '{0, 0, 0, -4095, 4095, -4095, 4095, 4095, -4095, 0, 20, 21};
      logic [21:0] buttons     = 22'b1001101001110010110011;
      jdm_req_type s;
      // calibration: horizontal sum lands on a half, vertical does not
      for (int i = 0; i < 10; i++) begin
         s.horizontal_sample = JDM_SAMPLE_BITS'((i % 2) ? 4095 : 0);
         s.vertical_sample   = JDM_SAMPLE_BITS'(calib_v[i]);
         s.button_level      = buttons[i];
         send_sample(s);
      end
      for (int i = 0; i < 12; i++) begin
         s.horizontal_sample =
            JDM_SAMPLE_BITS'(clamp_sample(tilt_check.h_centre + offs_h[i]));
         s.vertical_sample   =
            JDM_SAMPLE_BITS'(clamp_sample(tilt_check.v_centre + offs_v[i]));
         s.button_level      = buttons[10 + i];
         send_sample(s);
      end
      button_held = !buttons[21];
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         @(posedge clock);
         if (rsp_pop && !rsp_empty && !reset)
            tilt_check.check_tilt(rsp_data);
      end
   end

   initial begin
      int unsigned levels[6];
      levels = '{328, 0, 32768, $urandom_range(32768), 16384, $urandom_range(2000)};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         if (p != 0) begin
            wait_drained();
            write_deadzone(JDM_TILT_W'(levels[p]));
         end
         case (p % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 52; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 52; end
            default: begin send_idle_pct = 14; pop_stall_pct = 14; end
         endcase
         if (p == 0)
            send_directed();
         repeat (RANDOM_PER_PHASE)
            send_sample(random_sample());
      end
      wait_drained();
      repeat (40) @(posedge clock);
      $display("tb: %0d samples over 6 deadzone settings, %0d results checked",
               samples_sent, tilt_check.checked);
      $display("tb: %0d calibrating, %0d tilted, %0d presses, %0d releases",
               tilt_check.n_calib, tilt_check.n_tilted, tilt_check.n_press,
               tilt_check.n_release);
      if (tilt_check.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #3000000;
      $display("tb: timed out with %0d results outstanding", tilt_check.pending());
      $display("tb: errors");
      $finish;
   end
endmodule

### joystick_disc_mapper_unit.f
+incdir+design
design/jdm_pkg.sv
design/jdm_front.sv
design/jdm_queue.sv
design/jdm_isqrt.sv
design/jdm_back.sv
design/joystick_disc_mapper_unit.sv
tb/tb.sv
